// File: rtl/vva_pkg.sv
// ----------------------------------------------------------------------------
// vva_pkg: shared types and constants for the Verlet atom update
// Holds register indexes, reset values, stage counts, the sideband record
// that travels with each atom, and the magnitude and saturation helpers.
// ----------------------------------------------------------------------------
package vva_pkg;

    localparam int AXES       = 3;
    localparam int NUM_W      = 50;     // width of the kick numerator and quotient
    localparam int DIV_STAGES = NUM_W;  // one quotient bit per divider stage

    localparam logic [1:0] CFG_TIME_STEP  = 2'd0;
    localparam logic [1:0] CFG_FORCE_CONV = 2'd1;
    localparam logic [1:0] CFG_KE_CONV    = 2'd2;

    localparam logic [19:0] TIME_STEP_RST  = 20'd65536;
    localparam logic [31:0] FORCE_CONV_RST = 32'd41439992;
    localparam logic [23:0] KE_CONV_RST    = 24'd6792328;

    typedef struct packed {
        logic                  opcode;
        logic                  last;
        logic [15:0]           mass;
        logic [39:0]           mk;      // mass times ke_conv
        logic [AXES-1:0]       fneg;
        logic [AXES-1:0][31:0] vel;
        logic [AXES-1:0][31:0] pos;
    } side_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } sat_t;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        mag32 = x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic sat_t clamp52(input logic signed [51:0] x);
        sat_t r;
        if (x > 52'sd2147483647) begin
            r.val = 32'h7FFF_FFFF;
            r.sat = 1'b1;
        end else if (x < -52'sd2147483648) begin
            r.val = 32'h8000_0000;
            r.sat = 1'b1;
        end else begin
            r.val = x[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: rtl/vva_front.sv
// ----------------------------------------------------------------------------
// vva_front: kick numerator stages
// Registers the atom, forms |F|*force_conv*time_step in multiply stages
// s1 and s2 and a sum in s3, and keeps the bits that feed the mass divider.
// ----------------------------------------------------------------------------
module vva_front
    import vva_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic                  opcode,
    input  logic [15:0]           mass,
    input  logic [AXES-1:0][31:0] force_in,
    input  logic [AXES-1:0][31:0] vel_in,
    input  logic [AXES-1:0][31:0] pos_in,
    input  logic                  last_atom,
    input  logic [19:0]           time_step,
    input  logic [31:0]           force_conv,
    input  logic [23:0]           ke_conv,
    output logic                  out_valid,
    output side_t                 out_side,
    output logic [AXES-1:0][NUM_W-1:0] out_num
);

    logic                  s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    side_t                 s0_side_reg, s1_side_reg, s2_side_reg, s3_side_reg;
    logic [AXES-1:0][31:0] s0_force_reg;
    logic [AXES-1:0][63:0] s1_prod_reg;
    logic [AXES-1:0][51:0] s2_hi_reg, s2_lo_reg;
    logic [AXES-1:0][NUM_W-1:0] s3_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [83:0] sum;
        if (en)
        begin
            s0_side_reg.opcode <= opcode;
            s0_side_reg.last   <= last_atom;
            s0_side_reg.mass   <= mass;
            s0_side_reg.mk     <= '0;
            s0_side_reg.fneg   <= '0;
            s0_side_reg.vel    <= vel_in;
            s0_side_reg.pos    <= pos_in;
            s0_force_reg       <= force_in;

            s1_side_reg.opcode <= s0_side_reg.opcode;
            s1_side_reg.last   <= s0_side_reg.last;
            s1_side_reg.mass   <= s0_side_reg.mass;
            s1_side_reg.vel    <= s0_side_reg.vel;
            s1_side_reg.pos    <= s0_side_reg.pos;
            s1_side_reg.mk     <= {24'd0, s0_side_reg.mass} * {16'd0, ke_conv};
            for (int a = 0; a < AXES; a++)
            begin
                s1_side_reg.fneg[a] <= s0_force_reg[a][31];
                s1_prod_reg[a] <= {32'd0, mag32(s0_force_reg[a])} * {32'd0, force_conv};
            end

            s2_side_reg <= s1_side_reg;
            for (int a = 0; a < AXES; a++)
            begin
                s2_hi_reg[a] <= {20'd0, s1_prod_reg[a][63:32]} * {32'd0, time_step};
                s2_lo_reg[a] <= {20'd0, s1_prod_reg[a][31:0]} * {32'd0, time_step};
            end

            s3_side_reg <= s2_side_reg;
            for (int a = 0; a < AXES; a++)
            begin
                sum = {s2_hi_reg[a], 32'd0} + {32'd0, s2_lo_reg[a]};
                s3_num_reg[a] <= sum[82:33];
            end
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_side  = s3_side_reg;
    assign out_num   = s3_num_reg;

endmodule

// File: rtl/vva_div.sv
// ----------------------------------------------------------------------------
// vva_div: pipelined divider by atom mass
// Restoring division with one quotient bit per stage for all three axes;
// the sideband record moves along with the partial results.
// ----------------------------------------------------------------------------
module vva_div
    import vva_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  side_t                      in_side,
    input  logic [AXES-1:0][NUM_W-1:0] in_num,
    output logic                       out_valid,
    output side_t                      out_side,
    output logic [AXES-1:0][NUM_W-1:0] out_quo
);

    logic [DIV_STAGES-1:0]       vld_reg;
    side_t                       side_reg [DIV_STAGES];
    logic [AXES-1:0][15:0]       rem_reg  [DIV_STAGES];
    logic [AXES-1:0][NUM_W-1:0]  wrk_reg  [DIV_STAGES];

    function automatic logic [16+NUM_W-1:0] div_step(
        input logic [15:0]      rem,
        input logic [NUM_W-1:0] wrk,
        input logic [15:0]      m
    );
        logic [16:0] t;
        logic [16:0] d;
        t = {rem, wrk[NUM_W-1]};
        d = t - {1'b0, m};
        if (t >= {1'b0, m})
            div_step = {d[15:0], wrk[NUM_W-2:0], 1'b1};
        else
            div_step = {t[15:0], wrk[NUM_W-2:0], 1'b0};
    endfunction

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic                      prev_vld;
        side_t                     prev_side;
        logic [AXES-1:0][15:0]     prev_rem;
        logic [AXES-1:0][NUM_W-1:0] prev_wrk;

        if (k == 0)
        begin : g_first
            assign prev_vld  = in_valid;
            assign prev_side = in_side;
            assign prev_rem  = '0;
            assign prev_wrk  = in_num;
        end else
        begin : g_next
            assign prev_vld  = vld_reg[k-1];
            assign prev_side = side_reg[k-1];
            assign prev_rem  = rem_reg[k-1];
            assign prev_wrk  = wrk_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= prev_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= prev_side;
                for (int a = 0; a < AXES; a++)
                    {rem_reg[k][a], wrk_reg[k][a]} <=
                        div_step(prev_rem[a], prev_wrk[a], prev_side.mass);
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];
    assign out_quo   = wrk_reg[DIV_STAGES-1];

endmodule

// File: rtl/vva_back.sv
// ----------------------------------------------------------------------------
// vva_back: velocity, drift and kinetic energy stages
// Applies the kick with saturation, drifts the position for opcode 0,
// sums the squared velocity, scales it by mass and ke_conv, and holds the
// output word.
module vva_back
    import vva_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  side_t                      in_side,
    input  logic [AXES-1:0][NUM_W-1:0] in_quo,
    input  logic [19:0]                time_step,
    input  logic                       out_ready,
    output logic                       en,
    output logic                       out_valid,
    output logic [AXES-1:0][31:0]      new_vel,
    output logic [AXES-1:0][31:0]      new_pos,
    output logic [47:0]                kinetic_term,
    output logic                       error_flag,
    output logic                       last_out
);

    logic e0_valid_reg, e1_valid_reg, e2_valid_reg, e3_valid_reg, e4_valid_reg;
    logic e5_valid_reg, out_valid_reg;

    side_t                 e0_side_reg, e1_side_reg, e2_side_reg, e3_side_reg;
    side_t                 e4_side_reg, e5_side_reg;
    logic                  e0_err_reg, e1_err_reg, e2_err_reg, e3_err_reg;
    logic                  e4_err_reg, e5_err_reg;
    logic [AXES-1:0][31:0] e0_nv_reg, e1_nv_reg, e2_nv_reg, e3_nv_reg;
    logic [AXES-1:0][31:0] e4_nv_reg, e5_nv_reg;
    logic [AXES-1:0][51:0] e1_dprod_reg;
    logic [AXES-1:0][63:0] e1_sq_reg;
    logic [AXES-1:0][31:0] e2_np_reg, e3_np_reg, e4_np_reg, e5_np_reg;
    logic [63:0]           e2_s_reg;
    logic [63:0]           e3_ll_reg, e3_hl_reg, e4_ll_reg;
    logic [39:0]           e3_lh_reg, e3_hh_reg, e4_hh_reg;
    logic [64:0]           e4_mid_reg;
    logic [103:0]          e5_p_reg;

    logic [AXES-1:0][31:0] vel_out_reg, pos_out_reg;
    logic [47:0]           ke_out_reg;
    logic                  err_out_reg, last_out_reg;
    logic                  load_out;

    assign load_out = !out_valid_reg || out_ready;
    assign en       = load_out || !e5_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_valid_reg  <= 1'b0;
            e1_valid_reg  <= 1'b0;
            e2_valid_reg  <= 1'b0;
            e3_valid_reg  <= 1'b0;
            e4_valid_reg  <= 1'b0;
            e5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else
        begin
            if (en)
            begin
                e0_valid_reg <= in_valid;
                e1_valid_reg <= e0_valid_reg;
                e2_valid_reg <= e1_valid_reg;
                e3_valid_reg <= e2_valid_reg;
                e4_valid_reg <= e3_valid_reg;
                e5_valid_reg <= e4_valid_reg;
            end
            if (load_out)
                out_valid_reg <= e5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [51:0] vsum;
        logic signed [51:0] psum;
        logic        [31:0] vmag;
        sat_t               cl;
        logic               err;
        if (en)
        begin
            // Kick: v +/- dv, skipped when the mass is zero.
            e0_side_reg <= in_side;
            err = (in_side.mass == 16'd0);
            for (int a = 0; a < AXES; a++)
            begin
                if (in_side.fneg[a])
                    vsum = {{20{in_side.vel[a][31]}}, in_side.vel[a]} - {2'b00, in_quo[a]};
                else
                    vsum = {{20{in_side.vel[a][31]}}, in_side.vel[a]} + {2'b00, in_quo[a]};
                cl = clamp52(vsum);
                if (in_side.mass == 16'd0)
                    e0_nv_reg[a] <= in_side.vel[a];
                else
                begin
                    e0_nv_reg[a] <= cl.val;
                    err = err | cl.sat;
                end
            end
            e0_err_reg <= err;

            e1_side_reg <= e0_side_reg;
            e1_err_reg  <= e0_err_reg;
            e1_nv_reg   <= e0_nv_reg;
            for (int a = 0; a < AXES; a++)
            begin
                vmag = mag32(e0_nv_reg[a]);
                e1_dprod_reg[a] <= {20'd0, vmag} * {32'd0, time_step};
                e1_sq_reg[a]    <= {32'd0, vmag} * {32'd0, vmag};
            end

            // Drift for opcode 0; position passes for opcode 1.
            e2_side_reg <= e1_side_reg;
            e2_nv_reg   <= e1_nv_reg;
            err = e1_err_reg;
            for (int a = 0; a < AXES; a++)
            begin
                if (e1_nv_reg[a][31])
                    psum = {{20{e1_side_reg.pos[a][31]}}, e1_side_reg.pos[a]}
                         - {24'd0, e1_dprod_reg[a][51:24]};
                else
                    psum = {{20{e1_side_reg.pos[a][31]}}, e1_side_reg.pos[a]}
                         + {24'd0, e1_dprod_reg[a][51:24]};
                cl = clamp52(psum);
                if (e1_side_reg.opcode)
                    e2_np_reg[a] <= e1_side_reg.pos[a];
                else
                begin
                    e2_np_reg[a] <= cl.val;
                    err = err | cl.sat;
                end
            end
            e2_err_reg <= err;
            e2_s_reg   <= e1_sq_reg[0] + e1_sq_reg[1] + e1_sq_reg[2];

            // Energy: partial products of the squared sum and mass*ke_conv.
            e3_side_reg <= e2_side_reg;
            e3_err_reg  <= e2_err_reg;
            e3_nv_reg   <= e2_nv_reg;
            e3_np_reg   <= e2_np_reg;
            e3_ll_reg   <= {32'd0, e2_s_reg[31:0]}  * {32'd0, e2_side_reg.mk[31:0]};
            e3_hl_reg   <= {32'd0, e2_s_reg[63:32]} * {32'd0, e2_side_reg.mk[31:0]};
            e3_lh_reg   <= {8'd0, e2_s_reg[31:0]}   * {32'd0, e2_side_reg.mk[39:32]};
            e3_hh_reg   <= {8'd0, e2_s_reg[63:32]}  * {32'd0, e2_side_reg.mk[39:32]};

            e4_side_reg <= e3_side_reg;
            e4_err_reg  <= e3_err_reg;
            e4_nv_reg   <= e3_nv_reg;
            e4_np_reg   <= e3_np_reg;
            e4_ll_reg   <= e3_ll_reg;
            e4_hh_reg   <= e3_hh_reg;
            e4_mid_reg  <= {1'b0, e3_hl_reg} + {25'd0, e3_lh_reg};

            e5_side_reg <= e4_side_reg;
            e5_err_reg  <= e4_err_reg;
            e5_nv_reg   <= e4_nv_reg;
            e5_np_reg   <= e4_np_reg;
            e5_p_reg    <= {e4_hh_reg, 64'd0} + {7'd0, e4_mid_reg, 32'd0}
                         + {40'd0, e4_ll_reg};
        end

        if (load_out && e5_valid_reg)
        begin
            vel_out_reg  <= e5_nv_reg;
            pos_out_reg  <= e5_np_reg;
            last_out_reg <= e5_side_reg.last;
            if (|e5_p_reg[103:97])
            begin
                ke_out_reg  <= 48'hFFFF_FFFF_FFFF;
                err_out_reg <= 1'b1;
            end else
            begin
                ke_out_reg  <= e5_p_reg[96:49];
                err_out_reg <= e5_err_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign new_vel      = vel_out_reg;
    assign new_pos      = pos_out_reg;
    assign kinetic_term = ke_out_reg;
    assign error_flag   = err_out_reg;
    assign last_out     = last_out_reg;

endmodule

// File: rtl/velocity_verlet_atom_update_core.sv
// ----------------------------------------------------------------------------
// velocity_verlet_atom_update_core: streaming Verlet kick/drift engine
// Updates one atom per word: half kick, optional drift, kinetic energy term.
// ----------------------------------------------------------------------------
// Usage:
//   Atoms arrive on the in_valid/in_ready channel, one word per atom, and
//   results leave on out_valid/out_ready in the same order, one word each.
//   The cfg channel writes time_step, force_conv and ke_conv by index; it is
//   always ready and should only be used while no atom is in flight.
// Pipeline:
//   An accepted word passes four front stages (atom register s0,
//   multiplies in s1 and s2, sum in s3), then the mass divider, which
//   resolves one quotient bit per stage over 50 stages, then six kick,
//   drift and energy stages and the output register.
//   Throughput is one atom per cycle while the receiver keeps out_ready high.
// Reset:
//   rst_n clears every valid bit in the pipeline and the output register and
//   returns the three settings to their defaults.
// Stalls:
//   When the output word is held, the pipeline keeps advancing as long as
//   its last stage is empty, so in_ready only drops once a second finished
//   word is waiting behind the held one. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module velocity_verlet_atom_update_core
    import vva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] mass,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic signed [31:0] force_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic        last_atom,

    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_pos_z,
    output logic [47:0] kinetic_term,
    output logic        error_flag,
    output logic        last_out
);

    logic [19:0] time_step_reg;
    logic [31:0] force_conv_reg;
    logic [23:0] ke_conv_reg;

    logic                       en;
    logic                       fr_valid, dv_valid;
    side_t                      fr_side, dv_side;
    logic [AXES-1:0][NUM_W-1:0] fr_num, dv_quo;
    logic [AXES-1:0][31:0]      nv, np;

    // Settings registers; an index past the list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= TIME_STEP_RST;
            force_conv_reg <= FORCE_CONV_RST;
            ke_conv_reg    <= KE_CONV_RST;
        end else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIME_STEP:  time_step_reg  <= cfg_data[19:0];
                CFG_FORCE_CONV: force_conv_reg <= cfg_data;
                CFG_KE_CONV:    ke_conv_reg    <= cfg_data[23:0];
                default:        ;
            endcase
        end
    end

    // The whole pipeline moves together under one enable from the back end.
    assign in_ready = en;

    vva_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .opcode     (opcode),
        .mass       (mass),
        .force_in   ({force_z, force_y, force_x}),
        .vel_in     ({vel_z, vel_y, vel_x}),
        .pos_in     ({pos_z, pos_y, pos_x}),
        .last_atom  (last_atom),
        .time_step  (time_step_reg),
        .force_conv (force_conv_reg),
        .ke_conv    (ke_conv_reg),
        .out_valid  (fr_valid),
        .out_side   (fr_side),
        .out_num    (fr_num)
    );

    vva_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_side   (fr_side),
        .in_num    (fr_num),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    vva_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (dv_valid),
        .in_side      (dv_side),
        .in_quo       (dv_quo),
        .time_step    (time_step_reg),
        .out_ready    (out_ready),
        .en           (en),
        .out_valid    (out_valid),
        .new_vel      (nv),
        .new_pos      (np),
        .kinetic_term (kinetic_term),
        .error_flag   (error_flag),
        .last_out     (last_out)
    );

    assign new_vel_x = nv[0];
    assign new_vel_y = nv[1];
    assign new_vel_z = nv[2];
    assign new_pos_x = np[0];
    assign new_pos_y = np[1];
    assign new_pos_z = np[2];

endmodule

// File: rtl/vva_checker.sv
// ----------------------------------------------------------------------------
// vva_checker: port-level checks for the Verlet atom update core
// Watches the top-level ports only and is attached with a bind.
// ----------------------------------------------------------------------------
module vva_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_ready,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] new_vel_x,
    input logic [31:0] new_pos_z,
    input logic [47:0] kinetic_term,
    input logic        error_flag
);

    // No result word can be pending while reset is held.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // An empty output register never blocks the input side.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // The settings channel never back-pressures.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("settings channel not ready");

    // A held output word stays valid and keeps the checked fields stable.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kinetic_term)
        && $stable(new_vel_x) && $stable(new_pos_z) && $stable(error_flag))
        else $error("held output word changed");

endmodule

bind velocity_verlet_atom_update_core vva_checker u_vva_checker (.*);

// File: tb/sv/tb_velocity_verlet_atom_update_core.sv
// ----------------------------------------------------------------------------
// tb_velocity_verlet_atom_update_core: self-checking bench for the Verlet core
// Streams atoms through the core under several step, force and energy
// settings and several handshake idling patterns. Each result word is checked
// field by field against a typed answer or an in-bench fixed point predictor of the update.
// ----------------------------------------------------------------------------
module tb_velocity_verlet_atom_update_core;
    import vva_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes of the atom word and the one register index the core ignores.
    localparam logic       OP_KICK_DRIFT = 1'b0;
    localparam logic       OP_KICK_ONLY  = 1'b1;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;

    // Settle wait after each drain, before a setting is written and at the end
    // of the run.
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ATOMS  = 1330;
    localparam int PHASES        = 8;

    typedef struct packed {
        logic             op;
        logic [15:0]      mass;
        logic [2:0][31:0] f;
        logic [2:0][31:0] v;
        logic [2:0][31:0] r;
        logic             last;
    } atom_t;

    typedef struct packed {
        logic [2:0][31:0] nv;
        logic [2:0][31:0] np;
        logic [47:0]      ke;
        logic             err;
        logic             last;
    } update_t;

    typedef struct packed {
        atom_t   a;
        logic    typed;
        update_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [15:0] mass;
    logic signed [31:0] force_x, force_y, force_z;
    logic signed [31:0] vel_x, vel_y, vel_z;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic        last_atom;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;
    logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
    logic [47:0] kinetic_term;
    logic        error_flag;
    logic        last_out;

    velocity_verlet_atom_update_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .mass         (mass),
        .force_x      (force_x),
        .force_y      (force_y),
        .force_z      (force_z),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .vel_z        (vel_z),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .last_atom    (last_atom),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .new_vel_x    (new_vel_x),
        .new_vel_y    (new_vel_y),
        .new_vel_z    (new_vel_z),
        .new_pos_x    (new_pos_x),
        .new_pos_y    (new_pos_y),
        .new_pos_z    (new_pos_z),
        .kinetic_term (kinetic_term),
        .error_flag   (error_flag),
        .last_out     (last_out)
    );

    // Bench copy of the three settings, tracked as they are written.
    logic [19:0] step_q416;
    logic [31:0] fconv_q032;
    logic [23:0] keconv_q816;

    update_t pending_updates[$];
    int      mismatches;
    int      atoms_sent;
    int      words_seen;
    int      saturated_seen;
    int      cycle_count;
    int      idle_pct;
    int      stall_pct;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------------
    // Fixed point predictor of one atom update.
    // ------------------------------------------------------------------------
    function automatic longint abs_of(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint clamp_word(longint x, ref logic sat);
        if (x > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic update_t verlet_update(atom_t a);
        update_t     u;
        logic        sat;
        longint      f, v, r, dv, dr, nv;
        logic [127:0] wide;
        logic [127:0] vsq_sum;

        sat = (a.mass == 16'd0);
        vsq_sum = '0;
        for (int ax = 0; ax < 3; ax++)
        begin
            f = longint'($signed(a.f[ax]));
            v = longint'($signed(a.v[ax]));
            r = longint'($signed(a.r[ax]));
            // Half kick: the magnitude is truncated, then the force sign applied.
            nv = v;
            if (a.mass != 16'd0)
            begin
                wide = 128'(abs_of(f)) * 128'(fconv_q032);
                wide = wide * 128'(step_q416);
                wide = (wide >> 33) / 128'(a.mass);
                dv = longint'(wide[63:0]);
                nv = clamp_word((f < 0) ? v - dv : v + dv, sat);
            end
            u.nv[ax] = nv[31:0];
            // The drift uses the kicked velocity.
            if (a.op == OP_KICK_DRIFT)
            begin
                wide = (128'(abs_of(nv)) * 128'(step_q416)) >> 24;
                dr = longint'(wide[63:0]);
                u.np[ax] = 32'(clamp_word((nv < 0) ? r - dr : r + dr, sat));
            end
            else
            begin
                u.np[ax] = a.r[ax];
            end
            vsq_sum = vsq_sum + 128'(abs_of(nv)) * 128'(abs_of(nv));
        end
        // Energy saturates once the full product reaches 2^97.
        wide = vsq_sum * 128'(a.mass) * 128'(keconv_q816);
        if ((wide >> 97) != 0)
        begin
            u.ke = '1;
            sat = 1'b1;
        end
        else
        begin
            u.ke = wide[96:49];
        end
        u.err = sat;
        u.last = a.last;
        return u;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("mismatch on word %0d: %s got %h want %h", words_seen, what, got, want);
    endtask

    always @(posedge clk)
    begin
        update_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_updates.size() == 0)
            begin
                report_mismatch("unexpected word", 64'(kinetic_term), 64'd0);
            end
            else
            begin
                want = pending_updates.pop_front();
                if (new_vel_x !== want.nv[0])
                    report_mismatch("new_vel_x", 64'(new_vel_x), 64'(want.nv[0]));
                if (new_vel_y !== want.nv[1])
                    report_mismatch("new_vel_y", 64'(new_vel_y), 64'(want.nv[1]));
                if (new_vel_z !== want.nv[2])
                    report_mismatch("new_vel_z", 64'(new_vel_z), 64'(want.nv[2]));
                if (new_pos_x !== want.np[0])
                    report_mismatch("new_pos_x", 64'(new_pos_x), 64'(want.np[0]));
                if (new_pos_y !== want.np[1])
                    report_mismatch("new_pos_y", 64'(new_pos_y), 64'(want.np[1]));
                if (new_pos_z !== want.np[2])
                    report_mismatch("new_pos_z", 64'(new_pos_z), 64'(want.np[2]));
                if (kinetic_term !== want.ke)
                    report_mismatch("kinetic_term", 64'(kinetic_term), 64'(want.ke));
                if (error_flag !== want.err)
                    report_mismatch("error_flag", 64'(error_flag), 64'(want.err));
                if (last_out !== want.last)
                    report_mismatch("last_out", 64'(last_out), 64'(want.last));
                if (want.err)
                    saturated_seen++;
            end
            words_seen++;
        end
    end

    // The receiver stalls at the rate of the current phase.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_updates.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic atom_t make_atom(logic op, logic [15:0] m,
                                        logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                                        logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                        logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                        logic lst);
        atom_t a;
        a.op = op;
        a.mass = m;
        a.f = {fz, fy, fx};
        a.v = {vz, vy, vx};
        a.r = {pz, py, px};
        a.last = lst;
        return a;
    endfunction

    // A random word with a random magnitude, so that small values are common
    // while every bit still toggles.
    function automatic logic [31:0] spread_word();
        logic [31:0] w;
        w = $urandom;
        return $unsigned($signed(w) >>> $urandom_range(31));
    endfunction

    function automatic atom_t random_atom();
        atom_t a;
        a.op = 1'($urandom_range(1));
        case ($urandom_range(19))
            0:       a.mass = 16'd0;
            1:       a.mass = 16'hFFFF;
            2, 3:    a.mass = 16'($urandom);
            default: a.mass = 16'($urandom_range(16'h0080, 16'h4000));
        endcase
        for (int ax = 0; ax < 3; ax++)
        begin
            a.f[ax] = spread_word();
            a.v[ax] = spread_word();
            a.r[ax] = ($urandom_range(9) == 0) ? 32'($urandom) : spread_word();
        end
        a.last = ($urandom_range(15) == 0);
        return a;
    endfunction

    // Present one atom and hold it until the core takes it. The expected
    // update is queued at the accepting edge. The caller presents the next
    // atom or drops valid in the same time step.
    task automatic send_atom(atom_t a, logic typed, update_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        opcode    <= a.op;
        mass      <= a.mass;
        force_x   <= a.f[0];
        force_y   <= a.f[1];
        force_z   <= a.f[2];
        vel_x     <= a.v[0];
        vel_y     <= a.v[1];
        vel_z     <= a.v[2];
        pos_x     <= a.r[0];
        pos_y     <= a.r[1];
        pos_z     <= a.r[2];
        last_atom <= a.last;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_updates.push_back(typed ? want : verlet_update(a));
        atoms_sent++;
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
    endtask

    // Settings change only with the pipeline empty and settled.
    task automatic write_setting(logic [1:0] idx, logic [31:0] value);
        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TIME_STEP:  step_q416   = value[19:0];
            CFG_FORCE_CONV: fconv_q032  = value;
            CFG_KE_CONV:    keconv_q816 = value[23:0];
            default:        ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        row_t    rows[14];
        update_t none;

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TIME_STEP;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_KICK_DRIFT;
        mass = '0;
        {force_x, force_y, force_z} = '0;
        {vel_x, vel_y, vel_z} = '0;
        {pos_x, pos_y, pos_z} = '0;
        last_atom = 1'b0;
        out_ready = 1'b0;
        step_q416 = TIME_STEP_RST;
        fconv_q032 = FORCE_CONV_RST;
        keconv_q816 = KE_CONV_RST;
        mismatches = 0;
        atoms_sent = 0;
        words_seen = 0;
        saturated_seen = 0;
        cycle_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        none = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Rows with a typed answer are the ones that can be
        // read off directly: zero mass leaves a zero velocity alone and flags,
        // a still atom keeps its position and has no energy.
        foreach (rows[i])
            rows[i] = '0;
        rows[0].a = make_atom(OP_KICK_ONLY, 16'd0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        rows[0].typed = 1'b1;
        rows[0].want.err = 1'b1;
        rows[1].a = make_atom(OP_KICK_DRIFT, 16'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                              '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1);
        rows[1].typed = 1'b1;
        rows[1].want.np = {32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF};
        rows[1].want.err = 1'b1;
        rows[1].want.last = 1'b1;
        rows[2].a = make_atom(OP_KICK_DRIFT, 16'h0100, '0, '0, '0, '0, '0, '0,
                              32'h8000_0000, 32'h7FFF_FFFF, '0, 1'b1);
        rows[2].typed = 1'b1;
        rows[2].want.np = {32'h0, 32'h7FFF_FFFF, 32'h8000_0000};
        rows[2].want.last = 1'b1;
        // Largest push on the lightest atom: the kick saturates both ways.
        rows[3].a = make_atom(OP_KICK_DRIFT, 16'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000,
                              32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0, '0, 1'b0);
        rows[4].a = make_atom(OP_KICK_ONLY, 16'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                              32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0, '0, 1'b0);
        // Heaviest atom at full speed: the energy term saturates.
        rows[5].a = make_atom(OP_KICK_ONLY, 16'hFFFF, '0, '0, '0,
                              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0, 1'b0);
        // Positions at the edges drifting outward saturate.
        rows[6].a = make_atom(OP_KICK_DRIFT, 16'h0C00, '0, '0, '0,
                              32'h4000_0000, 32'hC000_0000, 32'h1000_0000,
                              32'h7FFF_0000, 32'h8000_FFFF, 32'h7FFF_FFFF, 1'b0);
        rows[7].a = make_atom(OP_KICK_DRIFT, 16'h0C00, 32'h0100_0000, 32'hFF00_0000, 32'h0000_0001,
                              32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFFF,
                              32'h0000_1000, 32'hFFFF_F000, 32'h0, 1'b0);
        rows[8].a = make_atom(OP_KICK_ONLY, 16'h1000, 32'h0100_0000, 32'hFF00_0000, 32'h5555_5555,
                              32'h0001_0000, 32'hFFFF_0000, 32'hAAAA_AAAA,
                              32'h1234_5678, 32'hEDCB_A987, 32'h5A5A_5A5A, 1'b1);
        rows[9].a = make_atom(OP_KICK_DRIFT, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                              '0, '0, '0, '0, '0, '0, 1'b0);
        rows[10].a = make_atom(OP_KICK_DRIFT, 16'h0001, 32'h0000_0001, 32'hFFFF_FFFF, '0,
                               32'h0000_0001, 32'hFFFF_FFFF, '0, '0, '0, '0, 1'b0);
        rows[11].a = make_atom(OP_KICK_DRIFT, 16'h8000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001,
                               32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFE,
                               32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001, 1'b1);
        rows[12].a = make_atom(OP_KICK_ONLY, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        rows[13].a = make_atom(OP_KICK_DRIFT, 16'h0100, 32'h0010_0000, 32'hFFF0_0000, 32'h0,
                               32'h1000_0000, 32'hF000_0000, 32'h0,
                               32'h0010_0000, 32'hFFF0_0000, 32'h0, 1'b0);
        foreach (rows[i])
            send_atom(rows[i].a, rows[i].typed, rows[i].want);

        // Random phases. Each one writes settings, with both extremes and the
        // ignored index among them, and takes one of four idling patterns.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_setting(CFG_UNUSED, 32'hFFFF_FFFF);
                end
                1:
                begin
                    write_setting(CFG_TIME_STEP, 32'hFFFF_FFFF);
                    write_setting(CFG_FORCE_CONV, 32'hFFFF_FFFF);
                    write_setting(CFG_KE_CONV, 32'hFFFF_FFFF);
                end
                2:
                begin
                    write_setting(CFG_TIME_STEP, 32'd0);
                    write_setting(CFG_FORCE_CONV, 32'd0);
                    write_setting(CFG_KE_CONV, 32'd0);
                end
                3:
                begin
                    write_setting(CFG_TIME_STEP, 32'd1);
                    write_setting(CFG_FORCE_CONV, 32'd1);
                    write_setting(CFG_KE_CONV, 32'd1);
                end
                default:
                begin
                    write_setting(CFG_TIME_STEP, $urandom);
                    write_setting(CFG_FORCE_CONV, $urandom);
                    write_setting(CFG_KE_CONV, $urandom);
                end
            endcase
            case (ph % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 71;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 71;
                end
                default:
                begin
                    idle_pct = 24;
                    stall_pct = 24;
                end
            endcase
            for (int n = 0; n < RANDOM_ATOMS / PHASES; n++)
            begin
                // Midway through one phase, let the core run completely dry.
                if (ph == 2 && n == RANDOM_ATOMS / (2 * PHASES))
                    drain_pipeline();
                send_atom(random_atom(), 1'b0, none);
            end
        end

        drain_pipeline();
        idle_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d atoms and %0d result words over %0d settings phases,",
                 atoms_sent, words_seen, PHASES);
        $display("%0d words flagged for zero mass or saturation, %0d mismatches",
                 saturated_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
